FILE: src/dtq_pkg.sv
// Package for the deadline timer queue: command, run state, status and ALU codes,
// the timer entry and result word layouts, and the sequencer state type.
// Depends on nothing; the top level and dtq_alu use it by scoped names.
package dtq_pkg;

	localparam int TIME_W = 48;
	localparam int KEY_W  = 16;
	localparam int PER_W  = 32;

	typedef enum logic [2:0] {
		CMD_REGISTER  = 3'd0,
		CMD_STOP      = 3'd1,
		CMD_RESTART   = 3'd2,
		CMD_HANDLE    = 3'd3,
		CMD_SET_STATE = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		RUN_RUNNING   = 2'd0,
		RUN_SUSPENDED = 2'd1,
		RUN_STEP      = 2'd2
	} run_t;

	typedef enum logic [1:0] {
		STAT_DONE      = 2'd0,
		STAT_FIRED     = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ALU_ADD = 3'd0,
		ALU_SUB = 3'd1,
		ALU_LTU = 3'd2,
		ALU_GTU = 3'd3,
		ALU_EQ  = 3'd4
	} alu_op_t;

	// one timer entry as stored in the table
	typedef struct packed {
		logic [KEY_W-1:0]  owner;
		logic [KEY_W-1:0]  slot;
		logic [PER_W-1:0]  period;
		logic [TIME_W-1:0] deadline;
		logic [TIME_W-1:0] start;
		logic              one_shot;
	} entry_t;

	// one buffered result word, before the queue head is attached
	typedef struct packed {
		status_t           status;
		logic [KEY_W-1:0]  owner;
		logic [KEY_W-1:0]  slot;
		logic [TIME_W-1:0] elapsed;
	} res_t;

	typedef struct packed {
		alu_op_t           op;
		logic [TIME_W-1:0] a;
		logic [TIME_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [TIME_W-1:0] res;
		logic              flag;
	} alu_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DECODE,
		ST_REG_DL,
		ST_INS_RD,
		ST_INS_CMP,
		ST_INS_PUT,
		ST_SCAN_CMP,
		ST_FIRE_RD,
		ST_FIRE_CHK,
		ST_FIRE_ND,
		ST_FIRE_EL,
		ST_REM_RD,
		ST_REM_MV,
		ST_REM_END,
		ST_FIRE_END,
		ST_SH_RD,
		ST_SH_DL,
		ST_SH_ST,
		ST_FINISH,
		ST_HEAD,
		ST_EMIT_RD,
		ST_EMIT_WR
	} state_t;

endpackage

FILE: src/deadline_timer_queue.sv
// Deadline timer queue: top level with the command sequencer.
// Depends on dtq_pkg, dtq_alu and dtq_ram.
//
// Commands arrive as words on the s_ channel (cmd in s_tuser); results
// leave as words on the m_ channel, status in m_tuser, m_tlast on the final
// result of each command. s_tready is high only while the sequencer is idle;
// one command is worked at a time through a simple dual-port entry table (one
// read and one write per cycle) and one shared 48-bit adder/comparator.
// Work per command:
//   register     insertion walks down from the tail
//   stop/restart one table read per entry scanned
//   handle       per fired entry, remove, then reinsert unless one-shot
//   set state    resuming shifts every entry, else no table work
// then the new head is read and each result moves into the output register.
// Handle results are buffered (up to FIRE_LIMIT) and sent once the new
// queue head is known, so every result carries next_deadline and
// queue_empty as they stand after the command. A stalled m_tready holds
// the output register and the sequencer waits; the next command is taken
// while the final result still waits in the output register.
// Reset empties the queue, sets the running state and a held clock of zero;
// table contents are not cleared.
module deadline_timer_queue #(
	parameter int TIMER_SLOTS = 32,
	parameter int FIRE_LIMIT  = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// now[47:0], owner[63:48], slot[79:64], period[111:80], once[112],
	// new_state[114:113], zero pad[119:115]
	input  logic [119:0] s_tdata,
	// cmd[2:0]
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// fired_owner[15:0], fired_slot[31:16], elapsed[79:32],
	// next_deadline[127:80], queue_empty[128], zero pad[135:129]
	output logic [135:0] m_tdata,
	// status[1:0]
	output logic [1:0]   m_tuser,
	output logic         m_tlast
);

	localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CW = $clog2(TIMER_SLOTS + 1);
	localparam int RW = (FIRE_LIMIT > 1) ? $clog2(FIRE_LIMIT) : 1;
	localparam int FW = $clog2(FIRE_LIMIT + 1);
	localparam logic [CW-1:0] SLOTS_C = CW'(TIMER_SLOTS);
	localparam logic [FW-1:0] LIMIT_C = FW'(FIRE_LIMIT);
	localparam int EW = $bits(dtq_pkg::entry_t);
	localparam int RSW = $bits(dtq_pkg::res_t);

	dtq_pkg::state_t  state_q, state_d;

	// captured command word
	dtq_pkg::cmd_t    cmd_q;
	logic [47:0]      now_q;
	logic [15:0]      owner_q;
	logic [15:0]      slot_q;
	logic [31:0]      period_q;
	logic             once_q;
	dtq_pkg::run_t    ns_q;

	// queue state
	logic [CW-1:0]    cnt_q, cnt_d;
	dtq_pkg::run_t    run_q, run_d;
	logic [47:0]      held_q, held_d;

	// sequencer work registers
	logic [CW-1:0]    idx_q, idx_d;
	logic [FW-1:0]    nres_q, nres_d;
	logic [FW-1:0]    k_q, k_d;
	logic             found_q, found_d;
	dtq_pkg::entry_t  rec_q, rec_d;
	logic [47:0]      acc_q, acc_d;
	logic [47:0]      head_q, head_d;
	logic             empty_q, empty_d;

	// output register
	logic             out_valid_q, out_valid_d;
	dtq_pkg::res_t    out_res_q, out_res_d;
	logic [47:0]      out_head_q, out_head_d;
	logic             out_empty_q, out_empty_d;
	logic             out_last_q, out_last_d;

	// table ports
	logic             tbl_we;
	logic [AW-1:0]    tbl_waddr;
	dtq_pkg::entry_t  tbl_wdata;
	logic [AW-1:0]    tbl_raddr;
	logic [EW-1:0]    tbl_rvec;
	dtq_pkg::entry_t  tbl_rdata;

	// result buffer ports
	logic             rb_we;
	dtq_pkg::res_t    rb_wdata;
	logic [RSW-1:0]   rb_rvec;
	dtq_pkg::res_t    rb_rdata;

	dtq_pkg::alu_req_t alu_req;
	dtq_pkg::alu_rsp_t alu_rsp;

	logic [CW-1:0]    idx_m1;
	logic [CW-1:0]    idx_m2;
	logic [CW-1:0]    idx_p1;
	logic [47:0]      samp;
	logic             ns_ok;
	logic             out_free;

	assign idx_m1    = idx_q - CW'(1);
	assign idx_m2    = idx_q - CW'(2);
	assign idx_p1    = idx_q + CW'(1);
	assign samp      = (run_q != dtq_pkg::RUN_SUSPENDED) ? now_q : held_q;
	assign ns_ok     = (ns_q == dtq_pkg::RUN_RUNNING) || (ns_q == dtq_pkg::RUN_SUSPENDED) ||
	                   (ns_q == dtq_pkg::RUN_STEP);
	assign out_free  = !out_valid_q || m_tready;
	assign tbl_rdata = dtq_pkg::entry_t'(tbl_rvec);
	assign rb_rdata  = dtq_pkg::res_t'(rb_rvec);

	dtq_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	dtq_ram #(
		.DEPTH (TIMER_SLOTS),
		.AW    (AW),
		.WIDTH (EW)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (tbl_rvec)
	);

	dtq_ram #(
		.DEPTH (FIRE_LIMIT),
		.AW    (RW),
		.WIDTH (RSW)
	) u_rbuf (
		.clk   (clk),
		.we    (rb_we),
		.waddr (nres_q[RW-1:0]),
		.wdata (rb_wdata),
		.raddr (k_q[RW-1:0]),
		.rdata (rb_rvec)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, datapath updates and memory port control
	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		run_d       = run_q;
		held_d      = held_q;
		idx_d       = idx_q;
		nres_d      = nres_q;
		k_d         = k_q;
		found_d     = found_q;
		rec_d       = rec_q;
		acc_d       = acc_q;
		head_d      = head_q;
		empty_d     = empty_q;
		out_valid_d = out_valid_q && !m_tready;
		out_res_d   = out_res_q;
		out_head_d  = out_head_q;
		out_empty_d = out_empty_q;
		out_last_d  = out_last_q;
		tbl_we      = 1'b0;
		tbl_waddr   = idx_q[AW-1:0];
		tbl_wdata   = rec_q;
		tbl_raddr   = '0;
		rb_we       = 1'b0;
		rb_wdata    = '{status: dtq_pkg::STAT_DONE, owner: '0, slot: '0, elapsed: '0};
		alu_req     = '{op: dtq_pkg::ALU_ADD, a: '0, b: '0};

		unique case (state_q)
			dtq_pkg::ST_IDLE: begin
				nres_d = '0;
				if (s_tvalid) begin
					state_d = dtq_pkg::ST_DECODE;
				end
			end

			dtq_pkg::ST_DECODE: begin
				rb_we  = 1'b1;
				nres_d = nres_q + FW'(1);
				state_d = dtq_pkg::ST_FINISH;
				case (cmd_q)
					dtq_pkg::CMD_REGISTER: begin
						held_d   = samp;
						rb_wdata = '{status: (cnt_q == SLOTS_C) ? dtq_pkg::STAT_FULL
						                                         : dtq_pkg::STAT_DONE,
						             owner: owner_q, slot: slot_q, elapsed: '0};
						if (cnt_q != SLOTS_C) begin
							state_d = dtq_pkg::ST_REG_DL;
						end
					end
					dtq_pkg::CMD_STOP, dtq_pkg::CMD_RESTART: begin
						idx_d   = '0;
						found_d = 1'b0;
						if (cnt_q == '0) begin
							rb_wdata = '{status: dtq_pkg::STAT_NOT_FOUND,
							             owner: owner_q, slot: slot_q, elapsed: '0};
						end else begin
							// result is written when the scan ends
							rb_we   = 1'b0;
							nres_d  = nres_q;
							state_d = dtq_pkg::ST_SCAN_CMP;
						end
					end
					dtq_pkg::CMD_HANDLE: begin
						if (run_q != dtq_pkg::RUN_SUSPENDED && cnt_q != '0) begin
							rb_we   = 1'b0;
							nres_d  = nres_q;
							held_d  = now_q;
							state_d = dtq_pkg::ST_FIRE_RD;
						end
					end
					dtq_pkg::CMD_SET_STATE: begin
						if (ns_ok) begin
							alu_req = '{op: dtq_pkg::ALU_SUB, a: now_q, b: held_q};
							acc_d   = alu_rsp.res;
							run_d   = ns_q;
							if (run_q != dtq_pkg::RUN_SUSPENDED ||
							    ns_q != dtq_pkg::RUN_SUSPENDED) begin
								held_d = now_q;
							end
							// resume: shift every entry by the time spent suspended
							if (run_q == dtq_pkg::RUN_SUSPENDED &&
							    ns_q != dtq_pkg::RUN_SUSPENDED && alu_rsp.res != '0) begin
								idx_d   = '0;
								state_d = dtq_pkg::ST_SH_RD;
							end
						end
					end
					default: begin
					end
				endcase
			end

			dtq_pkg::ST_REG_DL: begin
				alu_req = '{op: dtq_pkg::ALU_ADD, a: held_q, b: {16'd0, period_q}};
				rec_d   = '{owner: owner_q, slot: slot_q, period: period_q,
				            deadline: alu_rsp.res, start: held_q, one_shot: once_q};
				idx_d   = cnt_q;
				state_d = dtq_pkg::ST_INS_RD;
			end

			// insertion walks down from the tail, moving later deadlines up
			dtq_pkg::ST_INS_RD: begin
				if (idx_q == '0) begin
					state_d = dtq_pkg::ST_INS_PUT;
				end else begin
					tbl_raddr = idx_m1[AW-1:0];
					state_d   = dtq_pkg::ST_INS_CMP;
				end
			end

			dtq_pkg::ST_INS_CMP: begin
				alu_req = '{op: dtq_pkg::ALU_GTU, a: tbl_rdata.deadline, b: rec_q.deadline};
				tbl_we  = 1'b1;
				if (alu_rsp.flag) begin
					tbl_wdata = tbl_rdata;
					idx_d     = idx_m1;
					if (idx_m1 == '0) begin
						state_d = dtq_pkg::ST_INS_PUT;
					end else begin
						tbl_raddr = idx_m2[AW-1:0];
					end
				end else begin
					cnt_d   = cnt_q + CW'(1);
					state_d = (cmd_q == dtq_pkg::CMD_HANDLE) ? dtq_pkg::ST_FIRE_RD
					                                         : dtq_pkg::ST_FINISH;
				end
			end

			dtq_pkg::ST_INS_PUT: begin
				tbl_we  = 1'b1;
				cnt_d   = cnt_q + CW'(1);
				state_d = (cmd_q == dtq_pkg::CMD_HANDLE) ? dtq_pkg::ST_FIRE_RD
				                                         : dtq_pkg::ST_FINISH;
			end

			// key scan from the head; after a stop match, close the gap
			dtq_pkg::ST_SCAN_CMP: begin
				alu_req = '{op: dtq_pkg::ALU_EQ, a: {16'd0, tbl_rdata.owner, tbl_rdata.slot},
				            b: {16'd0, owner_q, slot_q}};
				rb_wdata = '{status: dtq_pkg::STAT_DONE, owner: owner_q, slot: slot_q,
				             elapsed: '0};
				if (found_q) begin
					tbl_we    = 1'b1;
					tbl_waddr = idx_m1[AW-1:0];
					tbl_wdata = tbl_rdata;
				end
				if (!found_q && alu_rsp.flag && cmd_q == dtq_pkg::CMD_RESTART) begin
					held_d          = samp;
					tbl_we          = 1'b1;
					tbl_wdata       = tbl_rdata;
					tbl_wdata.start = samp;
					rb_we           = 1'b1;
					nres_d          = nres_q + FW'(1);
					state_d         = dtq_pkg::ST_FINISH;
				end else if (idx_p1 == cnt_q) begin
					rb_we   = 1'b1;
					nres_d  = nres_q + FW'(1);
					state_d = dtq_pkg::ST_FINISH;
					if (found_q || alu_rsp.flag) begin
						cnt_d = cnt_q - CW'(1);
					end else begin
						rb_wdata.status = dtq_pkg::STAT_NOT_FOUND;
					end
				end else begin
					if (alu_rsp.flag) begin
						found_d = 1'b1;
					end
					tbl_raddr = idx_p1[AW-1:0];
					idx_d     = idx_p1;
				end
			end

			dtq_pkg::ST_FIRE_RD: begin
				if (nres_q == LIMIT_C || cnt_q == '0) begin
					state_d = dtq_pkg::ST_FIRE_END;
				end else begin
					state_d = dtq_pkg::ST_FIRE_CHK;
				end
			end

			dtq_pkg::ST_FIRE_CHK: begin
				alu_req = '{op: dtq_pkg::ALU_LTU, a: tbl_rdata.deadline, b: held_q};
				if (alu_rsp.flag) begin
					rec_d   = tbl_rdata;
					state_d = dtq_pkg::ST_FIRE_ND;
				end else begin
					state_d = dtq_pkg::ST_FIRE_END;
				end
			end

			dtq_pkg::ST_FIRE_ND: begin
				alu_req = '{op: dtq_pkg::ALU_ADD, a: rec_q.deadline, b: {16'd0, rec_q.period}};
				rec_d.deadline = alu_rsp.res;
				state_d        = dtq_pkg::ST_FIRE_EL;
			end

			dtq_pkg::ST_FIRE_EL: begin
				alu_req  = '{op: dtq_pkg::ALU_SUB, a: held_q, b: rec_q.start};
				rb_we    = 1'b1;
				rb_wdata = '{status: dtq_pkg::STAT_FIRED, owner: rec_q.owner,
				             slot: rec_q.slot, elapsed: alu_rsp.res};
				nres_d   = nres_q + FW'(1);
				idx_d    = CW'(1);
				state_d  = dtq_pkg::ST_REM_RD;
			end

			// drop the head: move every later entry down one place
			dtq_pkg::ST_REM_RD: begin
				if (idx_q < cnt_q) begin
					tbl_raddr = idx_q[AW-1:0];
					state_d   = dtq_pkg::ST_REM_MV;
				end else begin
					state_d = dtq_pkg::ST_REM_END;
				end
			end

			dtq_pkg::ST_REM_MV: begin
				tbl_we    = 1'b1;
				tbl_waddr = idx_m1[AW-1:0];
				tbl_wdata = tbl_rdata;
				if (idx_p1 == cnt_q) begin
					state_d = dtq_pkg::ST_REM_END;
				end else begin
					tbl_raddr = idx_p1[AW-1:0];
					idx_d     = idx_p1;
				end
			end

			dtq_pkg::ST_REM_END: begin
				cnt_d = cnt_q - CW'(1);
				if (rec_q.one_shot) begin
					state_d = dtq_pkg::ST_FIRE_RD;
				end else begin
					idx_d   = cnt_q - CW'(1);
					state_d = dtq_pkg::ST_INS_RD;
				end
			end

			dtq_pkg::ST_FIRE_END: begin
				if (nres_q == '0) begin
					rb_we  = 1'b1;
					nres_d = nres_q + FW'(1);
				end else if (run_q == dtq_pkg::RUN_STEP) begin
					run_d = dtq_pkg::RUN_SUSPENDED;
				end
				state_d = dtq_pkg::ST_FINISH;
			end

			// time shift sweep: deadline, then start, for each entry through SH_RD, SH_DL, SH_ST
			dtq_pkg::ST_SH_RD: begin
				if (idx_q == cnt_q) begin
					state_d = dtq_pkg::ST_FINISH;
				end else begin
					tbl_raddr = idx_q[AW-1:0];
					state_d   = dtq_pkg::ST_SH_DL;
				end
			end

			dtq_pkg::ST_SH_DL: begin
				alu_req        = '{op: dtq_pkg::ALU_ADD, a: tbl_rdata.deadline, b: acc_q};
				rec_d          = tbl_rdata;
				rec_d.deadline = alu_rsp.res;
				state_d        = dtq_pkg::ST_SH_ST;
			end

			dtq_pkg::ST_SH_ST: begin
				alu_req         = '{op: dtq_pkg::ALU_ADD, a: rec_q.start, b: acc_q};
				tbl_we          = 1'b1;
				tbl_wdata.start = alu_rsp.res;
				idx_d           = idx_p1;
				state_d         = dtq_pkg::ST_SH_RD;
			end

			dtq_pkg::ST_FINISH: begin
				state_d = dtq_pkg::ST_HEAD;
			end

			dtq_pkg::ST_HEAD: begin
				head_d  = (cnt_q != '0) ? tbl_rdata.deadline : '0;
				empty_d = (cnt_q == '0);
				k_d     = '0;
				state_d = dtq_pkg::ST_EMIT_RD;
			end

			dtq_pkg::ST_EMIT_RD: begin
				state_d = dtq_pkg::ST_EMIT_WR;
			end

			// move one buffered result into the output register
			dtq_pkg::ST_EMIT_WR: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					out_res_d   = rb_rdata;
					out_head_d  = head_q;
					out_empty_d = empty_q;
					out_last_d  = ((k_q + FW'(1)) == nres_q);
					k_d         = k_q + FW'(1);
					state_d     = ((k_q + FW'(1)) == nres_q) ? dtq_pkg::ST_IDLE
					                                         : dtq_pkg::ST_EMIT_RD;
				end
			end

			default: begin
				state_d = dtq_pkg::ST_IDLE;
			end
		endcase
	end

	// control and queue state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			run_q       <= dtq_pkg::RUN_RUNNING;
			held_q      <= '0;
			idx_q       <= '0;
			nres_q      <= '0;
			k_q         <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q       <= cnt_d;
			run_q       <= run_d;
			held_q      <= held_d;
			idx_q       <= idx_d;
			nres_q      <= nres_d;
			k_q         <= k_d;
			found_q     <= found_d;
			out_valid_q <= out_valid_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q    <= dtq_pkg::cmd_t'(s_tuser);
			now_q    <= s_tdata[47:0];
			owner_q  <= s_tdata[63:48];
			slot_q   <= s_tdata[79:64];
			period_q <= s_tdata[111:80];
			once_q   <= s_tdata[112];
			ns_q     <= dtq_pkg::run_t'(s_tdata[114:113]);
		end
		rec_q       <= rec_d;
		acc_q       <= acc_d;
		head_q      <= head_d;
		empty_q     <= empty_d;
		out_res_q   <= out_res_d;
		out_head_q  <= out_head_d;
		out_empty_q <= out_empty_d;
		out_last_q  <= out_last_d;
	end

	assign s_tready = (state_q == dtq_pkg::ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_empty_q, out_head_q, out_res_q.elapsed,
	                   out_res_q.slot, out_res_q.owner};
	assign m_tuser  = out_res_q.status;
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	// an accepted word takes the sequencer out of idle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("sequencer still ready after accepting a command");

	// the queue grows or shrinks by at most one entry per cycle
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |->
		(cnt_q == ($past(cnt_q) + CW'(1)) || cnt_q == ($past(cnt_q) - CW'(1))))
		else $error("entry count jumped by more than one");

	// the send phase always has at least one buffered result
	a_emit_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dtq_pkg::ST_EMIT_WR) |-> (nres_q != '0 && k_q < nres_q))
		else $error("sending with no buffered result left");
`endif

endmodule

FILE: src/dtq_alu.sv
// Shared 48-bit add, subtract and compare unit of the deadline timer queue.
// One adder serves every op; compares come from the borrow or a zero test.
// Depends on dtq_pkg.
module dtq_alu (
	input  dtq_pkg::alu_req_t req,
	output dtq_pkg::alu_rsp_t rsp
);

	logic                          sub;
	logic [dtq_pkg::TIME_W-1:0]    x;
	logic [dtq_pkg::TIME_W-1:0]    y;
	logic [dtq_pkg::TIME_W:0]      sum;

	// swap operands for greater-than so that the borrow answers it
	assign sub = (req.op != dtq_pkg::ALU_ADD);
	assign x   = (req.op == dtq_pkg::ALU_GTU) ? req.b : req.a;
	assign y   = (req.op == dtq_pkg::ALU_GTU) ? req.a : req.b;
	assign sum = {1'b0, x} + {1'b0, (sub ? ~y : y)} + {{dtq_pkg::TIME_W{1'b0}}, sub};

	// pick the flag for the op
	always_comb begin
		rsp.res = sum[dtq_pkg::TIME_W-1:0];
		unique case (req.op)
			dtq_pkg::ALU_ADD: rsp.flag = sum[dtq_pkg::TIME_W];
			dtq_pkg::ALU_SUB: rsp.flag = !sum[dtq_pkg::TIME_W];
			dtq_pkg::ALU_LTU: rsp.flag = !sum[dtq_pkg::TIME_W];
			dtq_pkg::ALU_GTU: rsp.flag = !sum[dtq_pkg::TIME_W];
			dtq_pkg::ALU_EQ:  rsp.flag = (sum[dtq_pkg::TIME_W-1:0] == '0);
			default:          rsp.flag = 1'b0;
		endcase
	end

endmodule

FILE: src/dtq_ram.sv
// Simple dual-port memory for the deadline timer queue: one write and one
// read address per cycle, read data registered. Depends on nothing.
module dtq_ram #(
	parameter int DEPTH = 32,
	parameter int AW    = 5,
	parameter int WIDTH = 161
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
